@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ design/lst_pkg.sv @@
package lst_pkg;
   localparam int IDX_W   = 10;
   localparam int ADD_W   = 32;
   localparam int SUM_W   = 64;
   localparam int COUNT_W = 11;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic [SUM_W-1:0] sum_type;
endpackage

@@ design/lazy_range_add_range_sum_tree.sv @@
// Lazy segment tree over up to MAX_ELEMENTS 64-bit values: range add and range sum.
// An item is taken at a rising edge with start high and busy low. req_op selects an
// add of req_add_value to every element of req_range_low..req_range_high, or a query
// of the sum over that span. A query gives one beat on rsp_valid/rsp_range_sum; an add
// gives none. The receiver cannot stall, so the strobe lasts exactly one cycle.
// Node sums and pending tags live in two memories of 2*MAX_ELEMENTS words with a
// registered read; a sequencer walks the tree with a small frame stack, one memory
// access per cycle. At each visited node the walk reads both memories, then sums a
// covered node on a query or tags it on an add; a split node first pushes any pending
// tag to its children, then descends left and right, and on adds its sum is refreshed
// from its children on the way back. An empty span is not walked; a query on it
// answers a sum of zero.
// csr_element_count is written on csr_valid and csr_ready; ready is high while the
// block holds no item and start is low, and during a clearing pass. A write, and
// reset, start a clearing pass that zeroes all 2*MAX_ELEMENTS words of both memories;
// busy stays high during it. Reset loads an element count of 1024, saturated to
// MAX_ELEMENTS; a count of zero acts as one.
`include "assert_macros.svh"
module lazy_range_add_range_sum_tree
   import lst_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_op,
   input  logic [IDX_W-1:0]          req_range_low,
   input  logic [IDX_W-1:0]          req_range_high,
   input  logic signed [ADD_W-1:0]   req_add_value,
   output logic                      rsp_valid,
   output logic signed [SUM_W-1:0]   rsp_range_sum,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [COUNT_W-1:0]        csr_element_count
);
   localparam int SLOTS = 2 * MAX_ELEMENTS;
   localparam int AW    = $clog2(SLOTS);
   localparam int NW    = AW + 1;
   localparam int EW    = $clog2(MAX_ELEMENTS);
   localparam int IW    = (EW > IDX_W) ? EW : IDX_W;
   localparam int LW    = IW + 1;
   localparam int DEPTH = AW + 1;
   localparam int SW    = $clog2(DEPTH);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CLEAR  = 4'd1;
   localparam logic [3:0] ST_ENTER  = 4'd2;
   localparam logic [3:0] ST_DESC   = 4'd3;
   localparam logic [3:0] ST_RESUME = 4'd4;
   localparam logic [3:0] ST_POP    = 4'd5;
   localparam logic [3:0] ST_P1     = 4'd6;
   localparam logic [3:0] ST_PR     = 4'd7;
   localparam logic [3:0] ST_PCLR   = 4'd8;
   localparam logic [3:0] ST_T0     = 4'd9;
   localparam logic [3:0] ST_T1     = 4'd10;
   localparam logic [3:0] ST_Q1     = 4'd11;
   localparam logic [3:0] ST_R0     = 4'd12;
   localparam logic [3:0] ST_R1     = 4'd13;
   localparam logic [3:0] ST_R2     = 4'd14;

   logic [3:0]         state_ff, state_in, ret_ff, ret_in;
   logic [SW-1:0]      sp_ff, sp_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               op_ff, op_in;
   logic [IW-1:0]      ql_ff, ql_in, qr_ff, qr_in;
   sum_type            val_ff, val_in, acc_ff, acc_in;
   logic [AW-1:0]      tag_node_ff, tag_node_in;
   logic [LW-1:0]      tag_len_ff, tag_len_in;
   sum_type            tag_val_ff, tag_val_in, prod_ff, prod_in;
   sum_type            pend_ff, pend_in, left_ff, left_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sum_type            rsp_sum_ff, rsp_sum_in;

   logic [NW-1:0]      stk_node_ff [DEPTH];
   logic [IW-1:0]      stk_lo_ff [DEPTH];
   logic [IW-1:0]      stk_hi_ff [DEPTH];
   logic               stk_right_ff [DEPTH];

   logic               stk_we, rt_we, rt_val;
   logic [SW-1:0]      stk_widx;
   logic [NW-1:0]      stk_wnode;
   logic [IW-1:0]      stk_wlo, stk_whi;

   sum_type            sum_mem [SLOTS];
   sum_type            tag_mem [SLOTS];
   sum_type            sum_rd_ff, tag_rd_ff;
   logic               sum_we, tag_we;
   logic [AW-1:0]      sum_waddr, tag_waddr, rd_addr;
   sum_type            sum_wdata, tag_wdata;

   logic [NW-1:0]      cur_node;
   logic [IW-1:0]      cur_lo, cur_hi, mid;
   logic               cur_right, in_tree, kids_in_tree, disjoint, covered, csr_fire;
   logic [AW-1:0]      cur_addr, left_addr, right_addr;
   logic [LW-1:0]      mid_w, len_full, len_left, len_right, cnt_ext, act_cnt;
   logic [IW-1:0]      last_idx;
   logic [SW-1:0]      sp_up;

   assign busy          = (state_ff != ST_IDLE);
   // A write is held off while an item is offered, so the two never share an edge.
   assign csr_ready     = ((state_ff == ST_IDLE) && !start) || (state_ff == ST_CLEAR);
   assign csr_fire      = csr_valid && csr_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

   assign cur_node  = stk_node_ff[sp_ff];
   assign cur_lo    = stk_lo_ff[sp_ff];
   assign cur_hi    = stk_hi_ff[sp_ff];
   assign cur_right = stk_right_ff[sp_ff];
   assign sp_up     = sp_ff + SW'(1);

   // Node numbers run up to twice the memory depth; the top bit marks a node outside it.
   assign in_tree      = !cur_node[AW];
   assign kids_in_tree = !cur_node[AW-1];
   assign cur_addr     = cur_node[AW-1:0];
   assign left_addr    = {cur_node[AW-2:0], 1'b0};
   assign right_addr   = {cur_node[AW-2:0], 1'b1};

   assign mid_w     = ({1'b0, cur_lo} + {1'b0, cur_hi}) >> 1;
   assign mid       = mid_w[IW-1:0];
   assign len_full  = {1'b0, cur_hi} - {1'b0, cur_lo} + LW'(1);
   assign len_left  = {1'b0, mid} - {1'b0, cur_lo} + LW'(1);
   assign len_right = {1'b0, cur_hi} - {1'b0, mid};
   assign disjoint  = (qr_ff < cur_lo) || (cur_hi < ql_ff);
   assign covered   = (ql_ff <= cur_lo) && (cur_hi <= qr_ff);

   assign cnt_ext  = LW'(count_ff);
   assign act_cnt  = (cnt_ext == '0) ? LW'(1) :
                     (cnt_ext > LW'(MAX_ELEMENTS)) ? LW'(MAX_ELEMENTS) : cnt_ext;
   assign last_idx = IW'(act_cnt - LW'(1));

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      sp_in        = sp_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      ql_in        = ql_ff;
      qr_in        = qr_ff;
      val_in       = val_ff;
      acc_in       = acc_ff;
      tag_node_in  = tag_node_ff;
      tag_len_in   = tag_len_ff;
      tag_val_in   = tag_val_ff;
      prod_in      = prod_ff;
      pend_in      = pend_ff;
      left_in      = left_ff;
      rsp_valid_in = 1'b0;
      rsp_sum_in   = rsp_sum_ff;
      stk_we       = 1'b0;
      stk_widx     = sp_up;
      stk_wnode    = '0;
      stk_wlo      = '0;
      stk_whi      = '0;
      rt_we        = 1'b0;
      rt_val       = 1'b0;
      sum_we       = 1'b0;
      tag_we       = 1'b0;
      sum_waddr    = cur_addr;
      tag_waddr    = cur_addr;
      sum_wdata    = '0;
      tag_wdata    = '0;
      rd_addr      = cur_addr;

      case (state_ff)
         ST_CLEAR: begin
            sum_we    = 1'b1;
            tag_we    = 1'b1;
            sum_waddr = clr_ff;
            tag_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in  = req_op;
               ql_in  = IW'(req_range_low);
               qr_in  = IW'(req_range_high);
               val_in = SUM_W'(req_add_value);
               acc_in = '0;
               if (req_range_low <= req_range_high) begin
                  stk_we    = 1'b1;
                  stk_widx  = '0;
                  stk_wnode = NW'(1);
                  stk_wlo   = '0;
                  stk_whi   = last_idx;
                  sp_in     = '0;
                  state_in  = ST_ENTER;
               end else if (req_op == OP_QUERY) begin
                  rsp_valid_in = 1'b1;
                  rsp_sum_in   = '0;
               end
            end
         end
         ST_ENTER: begin
            // Both memories are read at the node here, ready for the next state.
            if (!in_tree || disjoint) begin
               state_in = ST_POP;
            end else if (covered) begin
               if (op_ff == OP_QUERY) begin
                  state_in = ST_Q1;
               end else begin
                  tag_node_in = cur_addr;
                  tag_len_in  = len_full;
                  tag_val_in  = val_ff;
                  ret_in      = ST_POP;
                  state_in    = ST_T0;
               end
            end else begin
               state_in = ST_P1;
            end
         end
         ST_Q1: begin
            acc_in   = acc_ff + sum_rd_ff;
            state_in = ST_POP;
         end
         ST_P1: begin
            pend_in = tag_rd_ff;
            if (tag_rd_ff == '0) begin
               state_in = ST_DESC;
            end else if (!kids_in_tree) begin
               state_in = ST_PCLR;
            end else begin
               tag_node_in = left_addr;
               tag_len_in  = len_left;
               tag_val_in  = tag_rd_ff;
               ret_in      = ST_PR;
               state_in    = ST_T0;
            end
         end
         ST_PR: begin
            tag_node_in = right_addr;
            tag_len_in  = len_right;
            tag_val_in  = pend_ff;
            ret_in      = ST_PCLR;
            state_in    = ST_T0;
         end
         ST_PCLR: begin
            tag_we   = 1'b1;
            state_in = ST_DESC;
         end
         ST_T0: begin
            rd_addr  = tag_node_ff;
            prod_in  = tag_val_ff * SUM_W'(tag_len_ff);
            state_in = ST_T1;
         end
         ST_T1: begin
            sum_we    = 1'b1;
            tag_we    = 1'b1;
            sum_waddr = tag_node_ff;
            tag_waddr = tag_node_ff;
            sum_wdata = sum_rd_ff + prod_ff;
            tag_wdata = tag_rd_ff + tag_val_ff;
            state_in  = ret_ff;
         end
         ST_DESC: begin
            rt_we     = 1'b1;
            rt_val    = 1'b0;
            stk_we    = 1'b1;
            stk_wnode = {cur_node[NW-2:0], 1'b0};
            stk_wlo   = cur_lo;
            stk_whi   = mid;
            sp_in     = sp_up;
            state_in  = ST_ENTER;
         end
         ST_RESUME: begin
            if (!cur_right) begin
               rt_we     = 1'b1;
               rt_val    = 1'b1;
               stk_we    = 1'b1;
               stk_wnode = {cur_node[NW-2:0], 1'b1};
               stk_wlo   = mid + IW'(1);
               stk_whi   = cur_hi;
               sp_in     = sp_up;
               state_in  = ST_ENTER;
            end else if (op_ff == OP_ADD && kids_in_tree) begin
               state_in = ST_R0;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_R0: begin
            rd_addr  = left_addr;
            state_in = ST_R1;
         end
         ST_R1: begin
            rd_addr  = right_addr;
            left_in  = sum_rd_ff;
            state_in = ST_R2;
         end
         ST_R2: begin
            sum_we    = 1'b1;
            sum_wdata = left_ff + sum_rd_ff;
            state_in  = ST_POP;
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               if (op_ff == OP_QUERY) begin
                  rsp_valid_in = 1'b1;
                  rsp_sum_in   = acc_ff;
               end
               state_in = ST_IDLE;
            end else begin
               sp_in    = sp_ff - SW'(1);
               state_in = ST_RESUME;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A new element count changes the tree layout, so both memories are cleared.
      if (csr_fire) begin
         count_in = csr_element_count;
         clr_in   = '0;
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= COUNT_RESET;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      op_ff       <= op_in;
      ql_ff       <= ql_in;
      qr_ff       <= qr_in;
      val_ff      <= val_in;
      acc_ff      <= acc_in;
      tag_node_ff <= tag_node_in;
      tag_len_ff  <= tag_len_in;
      tag_val_ff  <= tag_val_in;
      prod_ff     <= prod_in;
      pend_ff     <= pend_in;
      left_ff     <= left_in;
      rsp_sum_ff  <= rsp_sum_in;
      if (stk_we) begin
         stk_node_ff[stk_widx] <= stk_wnode;
         stk_lo_ff[stk_widx]   <= stk_wlo;
         stk_hi_ff[stk_widx]   <= stk_whi;
      end
      if (rt_we) begin
         stk_right_ff[sp_ff] <= rt_val;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      sum_rd_ff <= sum_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_waddr] <= tag_wdata;
      end
      tag_rd_ff <= tag_mem[rd_addr];
   end

   `ASSERT_CLK(a_stack_bound, clock, reset, sp_ff <= SW'(DEPTH - 1), "frame stack overflow")
   `ASSERT_CLK(a_tag_order, clock, reset, state_ff == ST_T1 |-> $past(state_ff) == ST_T0, "tag write without read")
   `ASSERT_NEVER(a_rsp_on_add, clock, reset, rsp_valid_ff && op_ff == OP_ADD, "result beat for an add")
   `ASSERT_CLK(a_clear_walk, clock, reset, (state_ff == ST_CLEAR && !csr_fire && clr_ff != AW'(SLOTS - 1)) |=> clr_ff == $past(clr_ff) + AW'(1), "clearing pass skipped an entry")
endmodule

@@ sim/lazy_range_add_range_sum_tree_test.sv @@
module lazy_range_add_range_sum_tree_test;
   import lst_pkg::*;

   class range_sum_board;
      logic [SUM_W-1:0] node_total[2048];
      logic [SUM_W-1:0] node_tag[2048];
      logic [COUNT_W-1:0] count;
      sum_type sums_due[$];
      int mismatches;

      function new();
         count = COUNT_RESET;
         mismatches = 0;
         wipe();
      endfunction

      function void wipe();
         foreach (node_total[i]) begin
            node_total[i] = '0;
            node_tag[i] = '0;
         end
      endfunction

      function void set_count(logic [COUNT_W-1:0] value);
         count = value;
         wipe();
      endfunction

      function int unsigned last_index();
         if (count == 0) return 0;
         if (count > 1024) return 1023;
         return count - 1;
      endfunction

      function void tag_node(int unsigned node, int unsigned lo, int unsigned hi,
                             logic [SUM_W-1:0] v);
         if (node >= 2048) return;
         node_total[node] += 64'(hi - lo + 1) * v;
         node_tag[node] += v;
      endfunction

      function void push_down(int unsigned node, int unsigned lo, int unsigned hi);
         int unsigned mid;
         if (node >= 2048 || node_tag[node] == 0) return;
         mid = (lo + hi) / 2;
         tag_node(2 * node, lo, mid, node_tag[node]);
         tag_node(2 * node + 1, mid + 1, hi, node_tag[node]);
         node_tag[node] = '0;
      endfunction

      function void add_range(int unsigned node, int unsigned lo, int unsigned hi,
                              int unsigned ql, int unsigned qr, logic [SUM_W-1:0] v);
         int unsigned mid;
         if (node >= 2048 || qr < lo || hi < ql) return;
         if (ql <= lo && hi <= qr) begin
            tag_node(node, lo, hi, v);
            return;
         end
         push_down(node, lo, hi);
         mid = (lo + hi) / 2;
         add_range(2 * node, lo, mid, ql, qr, v);
         add_range(2 * node + 1, mid + 1, hi, ql, qr, v);
         if (2 * node + 1 < 2048)
            node_total[node] = node_total[2 * node] + node_total[2 * node + 1];
      endfunction

      function logic [SUM_W-1:0] sum_range(int unsigned node, int unsigned lo,
                                           int unsigned hi, int unsigned ql,
                                           int unsigned qr);
         int unsigned mid;
         if (node >= 2048 || qr < lo || hi < ql) return '0;
         if (ql <= lo && hi <= qr) return node_total[node];
         push_down(node, lo, hi);
         mid = (lo + hi) / 2;
         return sum_range(2 * node, lo, mid, ql, qr) +
                sum_range(2 * node + 1, mid + 1, hi, ql, qr);
      endfunction

      function void note_item(logic op, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
                              logic [ADD_W-1:0] value);
         logic [SUM_W-1:0] v;
         v = {{(SUM_W-ADD_W){value[ADD_W-1]}}, value};
         if (op == OP_ADD) begin
            if (lo <= hi) add_range(1, 0, last_index(), lo, hi, v);
         end else begin
            sums_due.push_back((lo <= hi) ? sum_range(1, 0, last_index(), lo, hi) : '0);
         end
      endfunction

      function void check_sum(logic [SUM_W-1:0] got);
         sum_type want;
         if (sums_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected sum beat: %0h", got);
            return;
         end
         want = sums_due.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("range_sum mismatch: expected %0h, actual %0h", want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_op = OP_ADD;
   logic [IDX_W-1:0] req_range_low = '0;
   logic [IDX_W-1:0] req_range_high = '0;
   logic signed [ADD_W-1:0] req_add_value = '0;
   logic rsp_valid;
   logic signed [SUM_W-1:0] rsp_range_sum;
   logic csr_valid = 0;
   logic csr_ready;
   logic [COUNT_W-1:0] csr_element_count = '0;

   range_sum_board board = new();
   int burst_left = 0;

   lazy_range_add_range_sum_tree dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_range_low(req_range_low), .req_range_high(req_range_high),
      .req_add_value(req_add_value), .rsp_valid(rsp_valid), .rsp_range_sum(rsp_range_sum),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_element_count(csr_element_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_sum(rsp_range_sum);
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_item(logic op, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
                            logic [ADD_W-1:0] value);
      if (burst_left == 0) begin
         start = 0;
         repeat ($urandom_range(1, 20)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      start = 1;
      req_op = op;
      req_range_low = lo;
      req_range_high = hi;
      req_add_value = value;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      board.note_item(op, lo, hi, value);
      @(negedge clock);
   endtask

   task automatic write_count(logic [COUNT_W-1:0] value);
      start = 0;
      burst_left = 0;
      while (board.sums_due.size() != 0) @(negedge clock);
      // Adds give no beat, so let any trailing add finish its walk.
      while (busy) @(negedge clock);
      csr_valid = 1;
      csr_element_count = value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      board.set_count(value);
      @(negedge clock);
      csr_valid = 0;
      csr_element_count = $urandom;
   endtask

   task automatic random_items(int n);
      int unsigned top, lo, hi, kind;
      for (int i = 0; i < n; i++) begin
         top = board.last_index();
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            lo = $urandom_range(0, top);
            hi = lo + $urandom_range(0, 15);
            if (hi > 1023) hi = 1023;
         end else if (kind < 9) begin
            lo = $urandom_range(0, 1023);
            hi = $urandom_range(0, 1023);
         end else begin
            lo = 0;
            hi = 1023;
         end
         send_item(1'($urandom_range(0, 1)), IDX_W'(lo), IDX_W'(hi), $urandom);
      end
   endtask

   initial begin
      logic [COUNT_W-1:0] counts[6] = '{11'd0, 11'd1, 11'd2, 11'd2047, 11'd7, 11'd0};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Full range, extreme values, single elements, inverted and partial spans.
      send_item(OP_ADD, 0, 1023, 32'h7fffffff);
      send_item(OP_QUERY, 0, 1023, 0);
      send_item(OP_ADD, 0, 1023, 32'h80000000);
      send_item(OP_QUERY, 0, 1023, 0);
      send_item(OP_ADD, 1023, 1023, 32'hffffffff);
      send_item(OP_ADD, 0, 0, 32'd5);
      send_item(OP_QUERY, 0, 0, 0);
      send_item(OP_QUERY, 1023, 1023, 0);
      send_item(OP_ADD, 900, 100, 32'd77);
      send_item(OP_QUERY, 900, 100, 0);
      send_item(OP_ADD, 3, 600, 32'h12345678);
      send_item(OP_QUERY, 2, 601, 0);
      send_item(OP_QUERY, 511, 512, 0);
      random_items(200);

      counts[5] = $urandom_range(3, 1023);
      for (int p = 0; p < 6; p++) begin
         write_count(counts[p]);
         send_item(OP_ADD, 0, 1023, $urandom);
         send_item(OP_QUERY, 0, 1023, 0);
         send_item(OP_QUERY, 1023, 1023, 0);
         random_items(70);
      end
      write_count(11'd1024);
      random_items(80);

      start = 0;
      while (board.sums_due.size() != 0) @(negedge clock);
      repeat (500) @(negedge clock);
      if (board.mismatches == 0 && board.sums_due.size() == 0)
         $display("lazy_range_add_range_sum_tree_test: clean");
      else
         $display("lazy_range_add_range_sum_tree_test: errors");
      $finish;
   end

   initial begin
      #40000000;
      $display("lazy_range_add_range_sum_tree_test: errors");
      $finish;
   end
endmodule
